// File: rtl/cpu_register_alu_execute_macros.svh
// assertion macros for the alu execute stage checker
`ifndef CPU_REGISTER_ALU_EXECUTE_MACROS_SVH
`define CPU_REGISTER_ALU_EXECUTE_MACROS_SVH

// same-cycle implication, checked on every rising edge out of reset
`define CRAE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CRAE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/crae_pkg.sv
// shared opcodes and status flag positions for the alu execute stage
package crae_pkg;

  typedef enum logic [5:0] {
    OP_ADC = 6'd0,  OP_SBC = 6'd1,  OP_AND = 6'd2,  OP_ORA = 6'd3,
    OP_EOR = 6'd4,  OP_CMP = 6'd5,  OP_CPX = 6'd6,  OP_CPY = 6'd7,
    OP_BIT = 6'd8,  OP_ASL = 6'd9,  OP_LSR = 6'd10, OP_ROL = 6'd11,
    OP_ROR = 6'd12, OP_INC = 6'd13, OP_DEC = 6'd14, OP_INX = 6'd15,
    OP_INY = 6'd16, OP_DEX = 6'd17, OP_DEY = 6'd18, OP_LDA = 6'd19,
    OP_LDX = 6'd20, OP_LDY = 6'd21, OP_STA = 6'd22, OP_STX = 6'd23,
    OP_STY = 6'd24, OP_TAX = 6'd25, OP_TAY = 6'd26, OP_TXA = 6'd27,
    OP_TYA = 6'd28, OP_TSX = 6'd29, OP_TXS = 6'd30, OP_CLC = 6'd31,
    OP_SEC = 6'd32, OP_CLI = 6'd33, OP_SEI = 6'd34, OP_CLD = 6'd35,
    OP_SED = 6'd36, OP_CLV = 6'd37, OP_BCC = 6'd38, OP_BCS = 6'd39,
    OP_BEQ = 6'd40, OP_BNE = 6'd41, OP_BMI = 6'd42, OP_BPL = 6'd43,
    OP_BVC = 6'd44, OP_BVS = 6'd45, OP_NOP = 6'd46
  } op_e;

  // status byte layout: N V - B D I Z C
  localparam int unsigned FLAG_C = 0;
  localparam int unsigned FLAG_Z = 1;
  localparam int unsigned FLAG_I = 2;
  localparam int unsigned FLAG_D = 3;
  localparam int unsigned FLAG_B = 4;
  localparam int unsigned FLAG_U = 5;
  localparam int unsigned FLAG_V = 6;
  localparam int unsigned FLAG_N = 7;

endpackage

// File: rtl/cpu_register_alu_execute.sv
// alu execute stage: register file, status flags and one-pass operation logic
//
//  channel | direction | handshake                | payload
//  --------+-----------+--------------------------+----------------------------------------
//  in      | to block  | in_valid_i / in_stall_o  | opcode, operand_byte, accumulator_mode
//  out     | from block| out_valid_o / out_stall_i| mem_write, write_data, branch_taken,
//          |           |                          | status_out, acc_out, x_out, y_out, sp_out
//
// one transfer in and one transfer out per cycle when neither side stalls
// an item passes the input register, then operation logic into the result register
// the operation logic is 8-bit adders and muxing, read from the architectural regs
// rst_ni clears the architectural registers and flags to zero and empties both stages
// an output stall holds the result and, once the input register is full, stalls the input
module cpu_register_alu_execute (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [5:0] opcode_i,
  input  logic [7:0] operand_byte_i,
  input  logic       accumulator_mode_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       mem_write_o,
  output logic [7:0] write_data_o,
  output logic       branch_taken_o,
  output logic [7:0] status_out_o,
  output logic [7:0] acc_out_o,
  output logic [7:0] x_out_o,
  output logic [7:0] y_out_o,
  output logic [7:0] sp_out_o
);
  import crae_pkg::*;

  // input register
  logic       in_valid_q;
  logic [5:0] opcode_q;
  logic [7:0] operand_q;
  logic       acc_mode_q;

  // result register; architectural regs double as the register fields of the result
  logic       out_valid_q;
  logic       mem_write_q, mem_write_d;
  logic [7:0] write_data_q, write_data_d;
  logic       branch_q, branch_d;
  logic [7:0] acc_q, acc_d;
  logic [7:0] x_q, x_d;
  logic [7:0] y_q, y_d;
  logic [7:0] sp_q, sp_d;
  logic [7:0] status_q, status_d;

  logic in_xfer;
  logic advance;

  // an item moves to the result stage whenever the result stage is empty or draining
  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;
  assign in_xfer    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_xfer || (in_valid_q && !advance);
    end
  end

  // payload of the input register needs no reset
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      opcode_q   <= opcode_i;
      operand_q  <= operand_byte_i;
      acc_mode_q <= accumulator_mode_i;
    end
  end

  // shared datapath pieces
  logic [7:0] adder_b;
  logic [8:0] adder_sum;
  logic [7:0] cmp_reg;
  logic [8:0] cmp_diff;
  logic [7:0] shift_src;
  logic       carry_in;

  assign carry_in  = status_q[FLAG_C];
  // sbc is adc of the inverted operand
  assign adder_b   = (op_e'(opcode_q) == OP_SBC) ? ~operand_q : operand_q;
  assign adder_sum = {1'b0, acc_q} + {1'b0, adder_b} + {8'd0, carry_in};

  always_comb begin
    case (op_e'(opcode_q))
      OP_CPX:  cmp_reg = x_q;
      OP_CPY:  cmp_reg = y_q;
      default: cmp_reg = acc_q;
    endcase
  end
  // borrow out in bit 8 means reg < operand
  assign cmp_diff  = {1'b0, cmp_reg} - {1'b0, operand_q};
  assign shift_src = acc_mode_q ? acc_q : operand_q;

  logic       nz_en;
  logic [7:0] nz_val;
  logic [7:0] shift_res;

  always_comb begin
    acc_d        = acc_q;
    x_d          = x_q;
    y_d          = y_q;
    sp_d         = sp_q;
    status_d     = status_q;
    mem_write_d  = 1'b0;
    write_data_d = 8'd0;
    branch_d     = 1'b0;
    nz_en        = 1'b0;
    nz_val       = 8'd0;
    shift_res    = 8'd0;

    case (op_e'(opcode_q))
      OP_ADC, OP_SBC: begin
        acc_d            = adder_sum[7:0];
        status_d[FLAG_C] = adder_sum[8];
        status_d[FLAG_V] = (adder_sum[7] ^ acc_q[7]) & (adder_sum[7] ^ adder_b[7]);
        nz_en            = 1'b1;
        nz_val           = adder_sum[7:0];
      end
      OP_AND: begin
        acc_d  = acc_q & operand_q;
        nz_en  = 1'b1;
        nz_val = acc_q & operand_q;
      end
      OP_ORA: begin
        acc_d  = acc_q | operand_q;
        nz_en  = 1'b1;
        nz_val = acc_q | operand_q;
      end
      OP_EOR: begin
        acc_d  = acc_q ^ operand_q;
        nz_en  = 1'b1;
        nz_val = acc_q ^ operand_q;
      end
      OP_CMP, OP_CPX, OP_CPY: begin
        status_d[FLAG_C] = !cmp_diff[8];
        status_d[FLAG_Z] = (cmp_diff[7:0] == 8'd0);
        status_d[FLAG_N] = cmp_diff[7];
      end
      OP_BIT: begin
        status_d[FLAG_Z] = ((acc_q & operand_q) == 8'd0);
        status_d[FLAG_V] = operand_q[6];
        status_d[FLAG_N] = operand_q[7];
      end
      OP_ASL, OP_LSR, OP_ROL, OP_ROR: begin
        case (op_e'(opcode_q))
          OP_ASL: begin
            shift_res        = {shift_src[6:0], 1'b0};
            status_d[FLAG_C] = shift_src[7];
          end
          OP_ROL: begin
            shift_res        = {shift_src[6:0], carry_in};
            status_d[FLAG_C] = shift_src[7];
          end
          OP_LSR: begin
            shift_res        = {1'b0, shift_src[7:1]};
            status_d[FLAG_C] = shift_src[0];
          end
          default: begin
            shift_res        = {carry_in, shift_src[7:1]};
            status_d[FLAG_C] = shift_src[0];
          end
        endcase
        nz_en  = 1'b1;
        nz_val = shift_res;
        if (acc_mode_q) begin
          acc_d = shift_res;
        end else begin
          mem_write_d  = 1'b1;
          write_data_d = shift_res;
        end
      end
      OP_INC: begin
        mem_write_d  = 1'b1;
        write_data_d = operand_q + 8'd1;
        nz_en        = 1'b1;
        nz_val       = operand_q + 8'd1;
      end
      OP_DEC: begin
        mem_write_d  = 1'b1;
        write_data_d = operand_q - 8'd1;
        nz_en        = 1'b1;
        nz_val       = operand_q - 8'd1;
      end
      OP_INX: begin
        x_d    = x_q + 8'd1;
        nz_en  = 1'b1;
        nz_val = x_q + 8'd1;
      end
      OP_INY: begin
        y_d    = y_q + 8'd1;
        nz_en  = 1'b1;
        nz_val = y_q + 8'd1;
      end
      OP_DEX: begin
        x_d    = x_q - 8'd1;
        nz_en  = 1'b1;
        nz_val = x_q - 8'd1;
      end
      OP_DEY: begin
        y_d    = y_q - 8'd1;
        nz_en  = 1'b1;
        nz_val = y_q - 8'd1;
      end
      OP_LDA: begin
        acc_d  = operand_q;
        nz_en  = 1'b1;
        nz_val = operand_q;
      end
      OP_LDX: begin
        x_d    = operand_q;
        nz_en  = 1'b1;
        nz_val = operand_q;
      end
      OP_LDY: begin
        y_d    = operand_q;
        nz_en  = 1'b1;
        nz_val = operand_q;
      end
      OP_STA: begin
        mem_write_d  = 1'b1;
        write_data_d = acc_q;
      end
      OP_STX: begin
        mem_write_d  = 1'b1;
        write_data_d = x_q;
      end
      OP_STY: begin
        mem_write_d  = 1'b1;
        write_data_d = y_q;
      end
      OP_TAX: begin
        x_d    = acc_q;
        nz_en  = 1'b1;
        nz_val = acc_q;
      end
      OP_TAY: begin
        y_d    = acc_q;
        nz_en  = 1'b1;
        nz_val = acc_q;
      end
      OP_TXA: begin
        acc_d  = x_q;
        nz_en  = 1'b1;
        nz_val = x_q;
      end
      OP_TYA: begin
        acc_d  = y_q;
        nz_en  = 1'b1;
        nz_val = y_q;
      end
      OP_TSX: begin
        x_d    = sp_q;
        nz_en  = 1'b1;
        nz_val = sp_q;
      end
      // flags untouched on txs
      OP_TXS: sp_d = x_q;
      OP_CLC: status_d[FLAG_C] = 1'b0;
      OP_SEC: status_d[FLAG_C] = 1'b1;
      OP_CLI: status_d[FLAG_I] = 1'b0;
      OP_SEI: status_d[FLAG_I] = 1'b1;
      OP_CLD: status_d[FLAG_D] = 1'b0;
      OP_SED: status_d[FLAG_D] = 1'b1;
      OP_CLV: status_d[FLAG_V] = 1'b0;
      OP_BCC: branch_d = !status_q[FLAG_C];
      OP_BCS: branch_d = status_q[FLAG_C];
      OP_BEQ: branch_d = status_q[FLAG_Z];
      OP_BNE: branch_d = !status_q[FLAG_Z];
      OP_BMI: branch_d = status_q[FLAG_N];
      OP_BPL: branch_d = !status_q[FLAG_N];
      OP_BVC: branch_d = !status_q[FLAG_V];
      OP_BVS: branch_d = status_q[FLAG_V];
      // nop and the unused codes above it change nothing
      default: begin
      end
    endcase

    if (nz_en) begin
      status_d[FLAG_Z] = (nz_val == 8'd0);
      status_d[FLAG_N] = nz_val[7];
    end
  end

  // architectural state commits together with the result transfer into the output stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      acc_q       <= 8'd0;
      x_q         <= 8'd0;
      y_q         <= 8'd0;
      sp_q        <= 8'd0;
      status_q    <= 8'd0;
    end else begin
      if (advance) begin
        out_valid_q <= 1'b1;
        acc_q       <= acc_d;
        x_q         <= x_d;
        y_q         <= y_d;
        sp_q        <= sp_d;
        status_q    <= status_d;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      mem_write_q  <= mem_write_d;
      write_data_q <= write_data_d;
      branch_q     <= branch_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign mem_write_o    = mem_write_q;
  assign write_data_o   = write_data_q;
  assign branch_taken_o = branch_q;
  assign status_out_o   = status_q;
  assign acc_out_o      = acc_q;
  assign x_out_o        = x_q;
  assign y_out_o        = y_q;
  assign sp_out_o       = sp_q;

endmodule

// File: rtl/crae_checker.sv
// port-level checker for the alu execute stage, bound to the top level
`include "cpu_register_alu_execute_macros.svh"

module crae_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_stall_o,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic       mem_write_o,
  input logic [7:0] write_data_o,
  input logic [7:0] status_out_o
);
  import crae_pkg::*;

  // the input side only backs up behind a stalled, full output stage
  `CRAE_ASSERT_NOW(a_in_stall_cause, in_stall_o, out_valid_o && out_stall_i, "input stall without output stall")

  // a stalled result is not dropped
  `CRAE_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o, "stalled result lost")

  // status bits 5 and 4 are never written, so they stay at their reset value
  `CRAE_ASSERT_NOW(a_status_fixed, out_valid_o, !status_out_o[FLAG_U] && !status_out_o[FLAG_B], "status bit 5 or 4 changed")

  // no write data without a write request
  `CRAE_ASSERT_NOW(a_wdata_zero, out_valid_o && !mem_write_o, write_data_o == 8'd0, "write data without write")

endmodule

bind cpu_register_alu_execute crae_checker u_crae_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_stall_o   (in_stall_o),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .mem_write_o  (mem_write_o),
  .write_data_o (write_data_o),
  .status_out_o (status_out_o)
);
